### sv/fp15a_pkg.sv
// fp15a_pkg: format constants, pipeline stage types and helper functions
// for the 15-bit floating-point adder. No dependencies.
package fp15a_pkg;

   // Operand format: sign[14], exponent[13:9], fraction[8:0]
   localparam int FRAC_BITS = 9;
   localparam int EXP_BITS  = 5;
   localparam int WORD_BITS = 15;

   // Aligned significand width: 10-bit significand shifted by up to 29, plus carry
   localparam int SUM_BITS  = 40;
   localparam int IDX_BITS  = 6;

   // Rounding width in significant bits
   localparam int RND_BITS  = 24;

   localparam logic [EXP_BITS-1:0]  EXP_ZERO = 5'd0;
   localparam logic [EXP_BITS-1:0]  EXP_INF  = 5'd31;
   localparam logic [WORD_BITS-1:0] POS_INF  = 15'h3E00;
   localparam logic [WORD_BITS-1:0] NEG_INF  = 15'h7E00;
   localparam logic [WORD_BITS-1:0] ZERO_VAL = 15'h0000;

   // After decode and swap
   typedef struct packed {
      logic                  special;
      logic [WORD_BITS-1:0]  spec_val;
      logic                  rs;
      logic                  sub;
      logic [EXP_BITS-1:0]   d;
      logic [EXP_BITS-1:0]   ex_small;
      logic [FRAC_BITS:0]    m_big;
      logic [FRAC_BITS:0]    m_small;
   } dec_type;

   // After alignment
   typedef struct packed {
      logic                  special;
      logic [WORD_BITS-1:0]  spec_val;
      logic                  rs;
      logic                  sub;
      logic [EXP_BITS-1:0]   d;
      logic [EXP_BITS-1:0]   ex_small;
      logic [SUM_BITS-1:0]   big;
      logic [FRAC_BITS:0]    m_small;
   } aln_type;

   // After add/subtract
   typedef struct packed {
      logic                  special;
      logic [WORD_BITS-1:0]  spec_val;
      logic                  rs;
      logic [EXP_BITS-1:0]   d;
      logic [EXP_BITS-1:0]   ex_small;
      logic [SUM_BITS-1:0]   s;
   } add_type;

   // After bit-length detection
   typedef struct packed {
      logic                  special;
      logic [WORD_BITS-1:0]  spec_val;
      logic                  rs;
      logic [EXP_BITS-1:0]   ex_small;
      logic [SUM_BITS-1:0]   s;
      logic [IDX_BITS-1:0]   n;
   } len_type;

   // After normalize and round decision
   typedef struct packed {
      logic                  special;
      logic [WORD_BITS-1:0]  spec_val;
      logic                  rs;
      logic [EXP_BITS-1:0]   ex_small;
      logic [IDX_BITS-1:0]   n;
      logic [RND_BITS-1:0]   norm;
      logic                  round_up;
   } nrm_type;

   // Signed infinity
   function automatic logic [WORD_BITS-1:0] inf_of(input logic sgn);
      return sgn ? NEG_INF : POS_INF;
   endfunction

   // Bit length of a 12-bit value (0 for zero)
   function automatic logic [IDX_BITS-1:0] bit_len12(input logic [11:0] v);
      logic [IDX_BITS-1:0] len;
      len = '0;
      for (int i = 0; i < 12; i++) begin
         if (v[i]) len = IDX_BITS'(i + 1);
      end
      return len;
   endfunction

endpackage

### sv/fp15_adder_core.sv
// fp15_adder_core: pipelined 15-bit floating-point adder.
// Depends on fp15a_pkg for format constants, stage types and helpers.

// The adder takes one operand pair per cycle while not stalled and returns each
// sum in order; a request passes stage registers one to five and then the
// output register before rsp_valid rises. Throughput is one request per clock
// when the result side does not stall, set by the
// pipeline: decode/swap, align shift, add/subtract, bit-length detect,
// normalize/round decision, then round increment and packing into the output
// register. Stall on the result side holds the pipe; empty stages still fill,
// so bubbles are squeezed out while a result waits.
module fp15_adder_core
   import fp15a_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [WORD_BITS-1:0] req_operand_a,
   input  logic [WORD_BITS-1:0] req_operand_b,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [WORD_BITS-1:0] rsp_sum
);

   logic    v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, rsp_valid_ff;
   logic    en1, en2, en3, en4, en5, en_out;
   dec_type s1_ff, s1_in;
   aln_type s2_ff, s2_in;
   add_type s3_ff, s3_in;
   len_type s4_ff, s4_in;
   nrm_type s5_ff, s5_in;
   logic [WORD_BITS-1:0] rsp_sum_ff, rsp_sum_in;

   // Stage advance: a stage loads when empty or when the next one moves
   assign en_out    = !rsp_valid_ff || !rsp_stall;
   assign en5       = !v5_ff || en_out;
   assign en4       = !v4_ff || en5;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_stall = !en1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_sum   = rsp_sum_ff;

   // Stage 1: decode, reserved exponents, result sign, swap by exponent
   always_comb begin
      logic                 sga, sgb, swap;
      logic [EXP_BITS-1:0]  exa, exb, ex_big;
      logic [FRAC_BITS-1:0] fra, frb;
      sga  = req_operand_a[14];
      sgb  = req_operand_b[14];
      exa  = req_operand_a[13:9];
      exb  = req_operand_b[13:9];
      fra  = req_operand_a[8:0];
      frb  = req_operand_b[8:0];
      swap = exa < exb;

      s1_in.rs = (req_operand_a[13:0] > req_operand_b[13:0]) ? sga : sgb;

      // A is checked before B
      s1_in.special  = 1'b1;
      s1_in.spec_val = ZERO_VAL;
      if (exa == EXP_ZERO) begin
         s1_in.spec_val = ZERO_VAL;
      end else if (exa == EXP_INF) begin
         s1_in.spec_val = inf_of(sga);
      end else if (exb == EXP_ZERO) begin
         s1_in.spec_val = ZERO_VAL;
      end else if (exb == EXP_INF) begin
         s1_in.spec_val = inf_of(sgb);
      end else begin
         s1_in.special = 1'b0;
      end

      s1_in.sub = sga ^ sgb;
      if (swap) begin
         ex_big           = exb;
         s1_in.ex_small   = exa;
         s1_in.m_big      = {1'b1, frb};
         s1_in.m_small    = {1'b1, fra};
      end else begin
         ex_big           = exa;
         s1_in.ex_small   = exb;
         s1_in.m_big      = {1'b1, fra};
         s1_in.m_small    = {1'b1, frb};
      end
      s1_in.d = ex_big - s1_in.ex_small;
   end

   // Stage 2: align the larger-exponent significand up by d
   always_comb begin
      s2_in.special  = s1_ff.special;
      s2_in.spec_val = s1_ff.spec_val;
      s2_in.rs       = s1_ff.rs;
      s2_in.sub      = s1_ff.sub;
      s2_in.d        = s1_ff.d;
      s2_in.ex_small = s1_ff.ex_small;
      s2_in.big      = SUM_BITS'(s1_ff.m_big) << s1_ff.d;
      s2_in.m_small  = s1_ff.m_small;
   end

   // Stage 3: add or take the magnitude of the difference
   always_comb begin
      logic [SUM_BITS-1:0] small_ext;
      small_ext      = SUM_BITS'(s2_ff.m_small);
      s3_in.special  = s2_ff.special;
      s3_in.spec_val = s2_ff.spec_val;
      s3_in.rs       = s2_ff.rs;
      s3_in.d        = s2_ff.d;
      s3_in.ex_small = s2_ff.ex_small;
      if (!s2_ff.sub) begin
         s3_in.s = s2_ff.big + small_ext;
      end else if (s2_ff.big >= small_ext) begin
         s3_in.s = s2_ff.big - small_ext;
      end else begin
         s3_in.s = small_ext - s2_ff.big;
      end
   end

   // Stage 4: bit length. Wide sums sit at 9+d..11+d bits; only narrow
   // sums (heavy cancellation) need a real leading-one search.
   always_comb begin
      logic [IDX_BITS-1:0] idx_lo, idx_hi;
      idx_lo         = IDX_BITS'(s3_ff.d) + IDX_BITS'(9);
      idx_hi         = IDX_BITS'(s3_ff.d) + IDX_BITS'(10);
      s4_in.rs       = s3_ff.rs;
      s4_in.ex_small = s3_ff.ex_small;
      s4_in.s        = s3_ff.s;
      s4_in.special  = s3_ff.special || (s3_ff.s == '0);
      s4_in.spec_val = s3_ff.special ? s3_ff.spec_val : ZERO_VAL;
      if (s3_ff.s[SUM_BITS-1:12] == '0) begin
         s4_in.n = bit_len12(s3_ff.s[11:0]);
      end else if (s3_ff.s[idx_hi]) begin
         s4_in.n = idx_hi + IDX_BITS'(1);
      end else if (s3_ff.s[idx_lo]) begin
         s4_in.n = idx_hi;
      end else begin
         s4_in.n = idx_lo;
      end
   end

   // Stage 5: normalize to 24 bits, decide round-to-nearest-even
   always_comb begin
      logic [IDX_BITS-1:0] sh, sh_m1, lsh;
      logic [RND_BITS-1:0] low24;
      logic [SUM_BITS-1:0] shifted, mask;
      logic                guard, sticky;
      sh      = s4_ff.n - IDX_BITS'(RND_BITS);
      sh_m1   = sh - IDX_BITS'(1);
      lsh     = IDX_BITS'(RND_BITS) - s4_ff.n;
      low24   = s4_ff.s[RND_BITS-1:0];
      shifted = s4_ff.s >> sh;
      mask    = (SUM_BITS'(1) << sh_m1) - SUM_BITS'(1);
      guard   = s4_ff.s[sh_m1];
      sticky  = |(s4_ff.s & mask);

      s5_in.special  = s4_ff.special;
      s5_in.spec_val = s4_ff.spec_val;
      s5_in.rs       = s4_ff.rs;
      s5_in.ex_small = s4_ff.ex_small;
      s5_in.n        = s4_ff.n;
      if (s4_ff.n > IDX_BITS'(RND_BITS)) begin
         s5_in.norm     = shifted[RND_BITS-1:0];
         s5_in.round_up = guard && (sticky || shifted[0]);
      end else begin
         s5_in.norm     = low24 << lsh;
         s5_in.round_up = 1'b0;
      end
   end

   // Stage 6: round increment, exponent, flush and saturate, pack
   always_comb begin
      logic [RND_BITS:0]      keep;
      logic [IDX_BITS-1:0]    p;
      logic signed [7:0]      e;
      logic [FRAC_BITS-1:0]   f;
      keep = {1'b0, s5_ff.norm} + (RND_BITS+1)'(s5_ff.round_up);
      if (keep[RND_BITS]) begin
         p = s5_ff.n;
         f = '0;
      end else begin
         p = s5_ff.n - IDX_BITS'(1);
         f = keep[RND_BITS-2 -: FRAC_BITS];
      end
      // e = smaller exponent + p - fraction bits
      e = $signed({3'b000, s5_ff.ex_small}) + $signed({2'b00, p}) - 8'sd9;
      if (s5_ff.special) begin
         rsp_sum_in = s5_ff.spec_val;
      end else if (e <= 8'sd0) begin
         rsp_sum_in = ZERO_VAL;
      end else if (e >= 8'sd31) begin
         rsp_sum_in = inf_of(s5_ff.rs);
      end else begin
         rsp_sum_in = {s5_ff.rs, e[EXP_BITS-1:0], f};
      end
   end

   // Pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1)    v1_ff        <= req_valid;
         if (en2)    v2_ff        <= v1_ff;
         if (en3)    v3_ff        <= v2_ff;
         if (en4)    v4_ff        <= v3_ff;
         if (en5)    v5_ff        <= v4_ff;
         if (en_out) rsp_valid_ff <= v5_ff;
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      if (en1)    s1_ff      <= s1_in;
      if (en2)    s2_ff      <= s2_in;
      if (en3)    s3_ff      <= s3_in;
      if (en4)    s4_ff      <= s4_in;
      if (en5)    s5_ff      <= s5_in;
      if (en_out) rsp_sum_ff <= rsp_sum_in;
   end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for fp15_adder_core. It drives operand pairs, checks each
// sum against a fixed sum or a bit-exact model in this file. Depends on fp15a_pkg.
module tb;
   import fp15a_pkg::*;

   localparam int NUM_RANDOM      = 1000;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int DRAIN_CYCLES    = 12;
   localparam int IDLE_PCT        = 37;
   localparam bit FIXED           = 1'b1;
   localparam bit MODELED         = 1'b0;

   typedef logic [WORD_BITS-1:0] word_type;

   // One request in flight: operands and the sum it should produce
   typedef struct packed {
      word_type a;
      word_type b;
      word_type sum;
   } sum_check_type;

   // Directed row: sum is only meaningful when fixed is set
   typedef struct packed {
      word_type a;
      word_type b;
      logic     fixed;
      word_type sum;
   } vector_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   word_type req_operand_a = '0;
   word_type req_operand_b = '0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   word_type rsp_sum;

   sum_check_type pending_sums[$];
   int errors       = 0;
   int quiet_cycles = 0;
   int hold_left    = 0;
   bit calm         = 1'b0;
   bit hold_request = 1'b0;

   // Zeros, infinities and their precedence, cancellation, negative difference,
   // underflow, overflow, then wide alignment and round-to-even ties
   vector_type directed_vectors [25] = '{
      {15'h0000, 15'h1E00, FIXED,   15'h0000},
      {15'h1E00, 15'h0000, FIXED,   15'h0000},
      {15'h3E00, 15'h1E00, FIXED,   15'h3E00},
      {15'h7FFF, 15'h1E00, FIXED,   15'h7E00},
      {15'h1E00, 15'h7E00, FIXED,   15'h7E00},
      {15'h5E00, 15'h7FFF, FIXED,   15'h7E00},
      {15'h0000, 15'h7E00, FIXED,   15'h0000},
      {15'h3E00, 15'h0000, FIXED,   15'h3E00},
      {15'h7FFF, 15'h7FFF, FIXED,   15'h7E00},
      {15'h0000, 15'h0000, FIXED,   15'h0000},
      {15'h1E00, 15'h1E00, FIXED,   15'h2000},
      {15'h1E00, 15'h5E00, FIXED,   15'h0000},
      {15'h5E00, 15'h1E00, FIXED,   15'h0000},
      {15'h1E00, 15'h5F00, FIXED,   15'h5C00},
      {15'h1E01, 15'h5E00, FIXED,   15'h0C00},
      {15'h0201, 15'h4200, FIXED,   15'h0000},
      {15'h3DFF, 15'h3DFF, FIXED,   15'h3E00},
      {15'h7DFF, 15'h7DFF, FIXED,   15'h7E00},
      {15'h3DFF, 15'h0200, MODELED, 15'h0000},
      {15'h0200, 15'h7DFF, MODELED, 15'h0000},
      {15'h3BFF, 15'h4001, MODELED, 15'h0000},
      {15'h3200, 15'h0A60, MODELED, 15'h0000},
      {15'h3200, 15'h0A20, MODELED, 15'h0000},
      {15'h3200, 15'h4A60, MODELED, 15'h0000},
      {15'h2AAA, 15'h5555, MODELED, 15'h0000}
   };

   fp15_adder_core i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_sum       (rsp_sum)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Number of significant bits in v (0 for zero)
   function automatic int msb_count(input logic [63:0] v);
      int cnt;
      cnt = 0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) cnt = i + 1;
      end
      return cnt;
   endfunction

   // Expected sum of two 15-bit floats
   function automatic word_type fp15_sum_of(input word_type a, input word_type b);
      logic                 res_sign, sgn_hi, sgn_lo;
      logic [EXP_BITS-1:0]  exp_hi, exp_lo;
      logic [FRAC_BITS-1:0] frac_hi, frac_lo, frac_out;
      logic [63:0]          mag, big, lit, keep, rem, half;
      int                   exp_diff, n, sh, p, e;
      res_sign = (a[13:0] > b[13:0]) ? a[14] : b[14];
      // reserved exponents, operand A first
      if (a[13:9] == EXP_ZERO) return ZERO_VAL;
      if (a[13:9] == EXP_INF) return a[14] ? NEG_INF : POS_INF;
      if (b[13:9] == EXP_ZERO) return ZERO_VAL;
      if (b[13:9] == EXP_INF) return b[14] ? NEG_INF : POS_INF;
      // larger exponent goes high
      if (a[13:9] < b[13:9]) begin
         {sgn_hi, exp_hi, frac_hi} = b;
         {sgn_lo, exp_lo, frac_lo} = a;
      end else begin
         {sgn_hi, exp_hi, frac_hi} = a;
         {sgn_lo, exp_lo, frac_lo} = b;
      end
      exp_diff = int'(exp_hi) - int'(exp_lo);
      big  = 64'({1'b1, frac_hi}) << exp_diff;
      lit  = 64'({1'b1, frac_lo});
      if (sgn_hi == sgn_lo) mag = big + lit;
      else mag = (big >= lit) ? big - lit : lit - big;
      if (mag == '0) return ZERO_VAL;
      // nearest-even at the rounding width
      n = msb_count(mag);
      if (n > RND_BITS) begin
         sh   = n - RND_BITS;
         keep = mag >> sh;
         rem  = mag & ((64'd1 << sh) - 64'd1);
         half = 64'd1 << (sh - 1);
         if (rem > half || (rem == half && keep[0])) keep = keep + 64'd1;
         mag = keep << sh;
      end
      p = msb_count(mag) - 1;
      e = int'(exp_hi) + p - FRAC_BITS - exp_diff;
      if (e <= 0) return ZERO_VAL;
      if (e >= 31) return res_sign ? NEG_INF : POS_INF;
      if (p >= FRAC_BITS) frac_out = FRAC_BITS'(mag >> (p - FRAC_BITS));
      else frac_out = FRAC_BITS'(mag << (FRAC_BITS - p));
      return {res_sign, EXP_BITS'(e), frac_out};
   endfunction

   // Mostly normal operands, with a few zeros, infinities and edge fractions
   function automatic word_type random_operand();
      logic [EXP_BITS-1:0]  ex;
      logic [FRAC_BITS-1:0] fr;
      int                   pick;
      pick = $urandom_range(99);
      if (pick < 5) ex = EXP_ZERO;
      else if (pick < 10) ex = EXP_INF;
      else ex = EXP_BITS'($urandom_range(30, 1));
      pick = $urandom_range(9);
      if (pick == 0) fr = '0;
      else if (pick == 1) fr = '1;
      else fr = FRAC_BITS'($urandom);
      return {1'($urandom), ex, fr};
   endfunction

   // Operand pair: raw noise, near cancellation, close exponents or independent
   task automatic make_pair(output word_type a, output word_type b);
      int pick, e;
      pick = $urandom_range(99);
      a = random_operand();
      if (pick < 10) begin
         a = WORD_BITS'($urandom);
         b = WORD_BITS'($urandom);
      end else if (pick < 25) begin
         b = {~a[14], a[13:0] ^ 14'($urandom_range(3))};
      end else if (pick < 65) begin
         e = int'(a[13:9]) + $urandom_range(6) - 3;
         if (e < 1) e = 1;
         if (e > 30) e = 30;
         b = {1'($urandom), EXP_BITS'(e), FRAC_BITS'($urandom)};
      end else begin
         b = random_operand();
      end
   endtask

   // Offer one request, wait for it to be taken, then record its sum
   task automatic send_request(input word_type a, input word_type b, input logic fixed,
                               input word_type typed_sum);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operand_a <= a;
      req_operand_b <= b;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_sums.push_back({a, b, fixed ? typed_sum : fp15_sum_of(a, b)});
   endtask

   // Stop offering until every recorded sum has come back
   task automatic wait_all_sums();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_sums.size() != 0);
   endtask

   // Result-side stall: random, off while calm, or one long hold-off on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_OFF_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (calm) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < IDLE_PCT);
      end
   end

   // Result checking and watchdog
   always @(posedge clock) begin
      sum_check_type expected;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles", $time, quiet_cycles);
            $display("FAIL");
            $finish;
         end else if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (pending_sums.size() == 0) begin
               $display("%0t: unexpected sum, expected none, got %h", $time, rsp_sum);
               errors = errors + 1;
            end else begin
               expected = pending_sums.pop_front();
               if (rsp_sum !== expected.sum) begin
                  $display("%0t: sum of %h + %h: expected %h, got %h", $time,
                           expected.a, expected.b, expected.sum, rsp_sum);
                  errors = errors + 1;
               end
            end
         end
      end
   end

   // Main sequence
   initial begin
      word_type a, b;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_vectors[i])
         send_request(directed_vectors[i].a, directed_vectors[i].b,
                      directed_vectors[i].fixed, directed_vectors[i].sum);
      wait_all_sums();

      for (int k = 0; k < NUM_RANDOM; k++) begin
         if (k == 150) hold_request = 1'b1;
         if (k == 400) calm = 1'b1;
         if (k == 600) calm = 1'b0;
         if (k == 800) wait_all_sums();
         make_pair(a, b);
         send_request(a, b, MODELED, ZERO_VAL);
      end

      wait_all_sums();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_sums.size() != 0) begin
         $display("%0t: %0d sums never arrived", $time, pending_sums.size());
         errors = errors + 1;
      end
      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
